// ===== hw/rtl/lattice_word_checksum_engine_assert.svh =====
// assertion macros used by lwc_core of the checksum engine rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef LATTICE_WORD_CHECKSUM_ENGINE_ASSERT_SVH
`define LATTICE_WORD_CHECKSUM_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum engine assertion failed");

// next-cycle implication, checked outside reset
`define LWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum engine assertion failed");

`endif

// ===== hw/rtl/lwc_pkg.sv =====
// shared types, constants and functions of the lattice word checksum engine
// no dependencies
`default_nettype none

package lwc_pkg;

    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned SUM_W     = 32;
    localparam int unsigned POS_W     = 5;

    localparam logic [POS_W-1:0] POS29_LAST = 5'd28;
    localparam logic [POS_W-1:0] POS31_LAST = 5'd30;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // register index, taken from paddr[2]
    localparam logic REG_SINGLE = 1'b0;
    localparam logic REG_BIG    = 1'b1;

    typedef struct packed {
        logic single_precision;
        logic big_endian_output;
    } cfg_t;

    // first member sits in the top bits, so sum_check lands at bit 0
    typedef struct packed {
        logic [SUM_W-1:0] crc31_check;
        logic [SUM_W-1:0] crc29_check;
        logic [SUM_W-1:0] rot31_check;
        logic [SUM_W-1:0] rot29_check;
        logic [SUM_W-1:0] sum_check;
    } sums_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [POS_W-1:0] r);
        logic [63:0] d;
        d = {v, v} << r;
        return d[63:32];
    endfunction

    function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p,
                                                  input logic [POS_W-1:0] last);
        return (p == last) ? '0 : p + 5'd1;
    endfunction

    function automatic logic [31:0] fold_word(input logic [DATA_W-1:0] w, input logic single);
        return single ? w[31:0] : w[31:0] + w[63:32];
    endfunction

    // bytes in the order they enter the crc, first byte lowest
    function automatic logic [DATA_W-1:0] order_bytes(input logic [DATA_W-1:0] w,
                                                      input logic single,
                                                      input logic big);
        logic [DATA_W-1:0] m;
        int i;
        m = '0;
        for (i = 0; i < 8; i++)
        begin
            if (!big)
                m[8*i +: 8] = w[8*i +: 8];
            else if (!single)
                m[8*i +: 8] = w[8*(7-i) +: 8];
            else if (i < 4)
                m[8*i +: 8] = w[8*(3-i) +: 8];
        end
        return m;
    endfunction

    // reflected crc-32 over four or eight bytes, unrolled
    function automatic logic [31:0] crc_bytes(input logic [31:0] crc,
                                              input logic [DATA_W-1:0] m,
                                              input logic single);
        logic [31:0] c;
        int b;
        int k;
        c = crc;
        for (b = 0; b < 8; b++)
        begin
            if (b < 4 || !single)
            begin
                c = c ^ {24'h0, m[8*b +: 8]};
                for (k = 0; k < 8; k++)
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lattice_word_checksum_engine.sv =====
// lattice word checksum engine: a beat is registered in the input stage, then its result in the accumulators
// throughput one word per cycle while m_tready drains the result; the crc and rotations of a word are combinational
// the accumulators themselves are the result register, so a stalled result holds them
// rst_n (asynchronous, active low) clears checksums, positions and configuration,
// sets the site crc to all ones and empties both stages
// depends on lwc_pkg, lwc_regs and lwc_core
`default_nettype none

module lattice_word_checksum_engine
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // apb configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lwc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // word stream in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lwc_pkg::DATA_W-1:0]  s_tdata,   // [63:0] data_word
    input  wire logic                        s_tuser,   // [0] start_lattice
    input  wire logic                        s_tlast,   // last_of_site
    // checksum stream out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [5*lwc_pkg::SUM_W-1:0]      m_tdata    // sum, rot29, rot31, crc29, crc31
);

    lwc_pkg::cfg_t              cfg;
    lwc_pkg::sums_t             sums;

    // input stage
    logic                       in_valid_reg, in_valid_next;
    logic [lwc_pkg::DATA_W-1:0] in_data_reg;
    logic                       in_start_reg;
    logic                       in_last_reg;

    // result stage valid; the payload is the accumulator set in the core
    logic                       out_valid_reg, out_valid_next;

    logic                       advance;
    logic                       take;

    lwc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held word moves on when the result slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the input stage, loaded on every accepted beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    lwc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_word     (in_data_reg),
        .start_lattice (in_start_reg),
        .last_of_site  (in_last_reg),
        .cfg           (cfg),
        .sums          (sums)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sums;

endmodule

`default_nettype wire

// ===== hw/rtl/lwc_regs.sv =====
// apb configuration registers of the checksum engine
// depends on lwc_pkg
`default_nettype none

module lwc_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lwc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output lwc_pkg::cfg_t                    cfg
);

    lwc_pkg::cfg_t cfg_reg;
    lwc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic          rd_bit;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                lwc_pkg::REG_SINGLE: cfg_next.single_precision  = pwdata[0];
                lwc_pkg::REG_BIG:    cfg_next.big_endian_output = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lwc_pkg::REG_SINGLE: rd_bit = cfg_reg.single_precision;
            lwc_pkg::REG_BIG:    rd_bit = cfg_reg.big_endian_output;
            default:             rd_bit = 1'b0;
        endcase
    end

    assign prdata = {31'h0, rd_bit};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lwc_core.sv =====
// checksum state and single-pass update logic of the checksum engine
// depends on lwc_pkg and lattice_word_checksum_engine_assert.svh
`default_nettype none
`include "lattice_word_checksum_engine_assert.svh"

module lwc_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [lwc_pkg::DATA_W-1:0]  data_word,
    input  wire logic                        start_lattice,
    input  wire logic                        last_of_site,
    input  wire lwc_pkg::cfg_t               cfg,
    output lwc_pkg::sums_t                   sums
);

    lwc_pkg::sums_t             acc_reg, acc_next, acc_base;
    logic [lwc_pkg::POS_W-1:0]  wpos29_reg, wpos29_next, wpos29_base;
    logic [lwc_pkg::POS_W-1:0]  wpos31_reg, wpos31_next, wpos31_base;
    logic [lwc_pkg::POS_W-1:0]  spos29_reg, spos29_next, spos29_base;
    logic [lwc_pkg::POS_W-1:0]  spos31_reg, spos31_next, spos31_base;
    logic [31:0]                crc_reg, crc_next, crc_base, crc_upd, crc_out;
    logic [31:0]                folded;
    logic [lwc_pkg::DATA_W-1:0] msg;

    // start flag clears checksums and positions and sets the site crc to all ones before the word is taken in
    always_comb
    begin
        if (start_lattice)
        begin
            acc_base    = '0;
            wpos29_base = '0;
            wpos31_base = '0;
            spos29_base = '0;
            spos31_base = '0;
            crc_base    = lwc_pkg::CRC_INIT;
        end
        else
        begin
            acc_base    = acc_reg;
            wpos29_base = wpos29_reg;
            wpos31_base = wpos31_reg;
            spos29_base = spos29_reg;
            spos31_base = spos31_reg;
            crc_base    = crc_reg;
        end
    end

    assign folded  = lwc_pkg::fold_word(data_word, cfg.single_precision);
    assign msg     = lwc_pkg::order_bytes(data_word, cfg.single_precision,
                                          cfg.big_endian_output);
    assign crc_upd = lwc_pkg::crc_bytes(crc_base, msg, cfg.single_precision);
    assign crc_out = ~crc_upd;

    always_comb
    begin
        acc_next    = acc_reg;
        wpos29_next = wpos29_reg;
        wpos31_next = wpos31_reg;
        spos29_next = spos29_reg;
        spos31_next = spos31_reg;
        crc_next    = crc_reg;
        if (step)
        begin
            acc_next.sum_check   = acc_base.sum_check + folded;
            acc_next.rot29_check = acc_base.rot29_check ^ lwc_pkg::rotl32(folded, wpos29_base);
            acc_next.rot31_check = acc_base.rot31_check ^ lwc_pkg::rotl32(folded, wpos31_base);
            wpos29_next = lwc_pkg::pos_next(wpos29_base, lwc_pkg::POS29_LAST);
            wpos31_next = lwc_pkg::pos_next(wpos31_base, lwc_pkg::POS31_LAST);
            acc_next.crc29_check = acc_base.crc29_check;
            acc_next.crc31_check = acc_base.crc31_check;
            crc_next    = crc_upd;
            spos29_next = spos29_base;
            spos31_next = spos31_base;
            if (last_of_site)
            begin
                acc_next.crc29_check = acc_base.crc29_check ^
                                       lwc_pkg::rotl32(crc_out, spos29_base);
                acc_next.crc31_check = acc_base.crc31_check ^
                                       lwc_pkg::rotl32(crc_out, spos31_base);
                spos29_next = lwc_pkg::pos_next(spos29_base, lwc_pkg::POS29_LAST);
                spos31_next = lwc_pkg::pos_next(spos31_base, lwc_pkg::POS31_LAST);
                crc_next    = lwc_pkg::CRC_INIT;
            end
        end
    end

    assign sums = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            wpos29_reg <= '0;
            wpos31_reg <= '0;
            spos29_reg <= '0;
            spos31_reg <= '0;
            crc_reg    <= lwc_pkg::CRC_INIT;
        end
        else
        begin
            acc_reg    <= acc_next;
            wpos29_reg <= wpos29_next;
            wpos31_reg <= wpos31_next;
            spos29_reg <= spos29_next;
            spos31_reg <= spos31_next;
            crc_reg    <= crc_next;
        end
    end

    `LWC_ASSERT_NOW(a_wpos_range, 1'b1, (wpos29_reg <= lwc_pkg::POS29_LAST) && (wpos31_reg <= lwc_pkg::POS31_LAST))
    `LWC_ASSERT_NOW(a_spos_range, 1'b1, (spos29_reg <= lwc_pkg::POS29_LAST) && (spos31_reg <= lwc_pkg::POS31_LAST))
    `LWC_ASSERT_NEXT(a_site_close, step && last_of_site, crc_reg == lwc_pkg::CRC_INIT)
    `LWC_ASSERT_NEXT(a_start_pos, step && start_lattice, (wpos29_reg == 5'd1) && (wpos31_reg == 5'd1))
    `LWC_ASSERT_NEXT(a_idle_hold, !step, $stable(acc_reg) && $stable(crc_reg))

endmodule

`default_nettype wire
